FILE: sv/sf_pkg.sv
`timescale 1ns / 1ps
package sf_pkg;

  localparam int ANG_FRAC  = 30;
  localparam int IN_FRAC   = 16;
  localparam int OUT_FRAC  = 14;
  localparam int ANG_SHIFT = ANG_FRAC - IN_FRAC;
  localparam int Q_BITS    = 17;

  localparam logic [33:0] TWO_PI_Q = 34'd6746518852;

  localparam logic signed [34:0] TWO_PI_S  = 35'sd6746518852;
  localparam logic signed [34:0] PI_S      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_S = 35'sd1686629713;
  localparam logic signed [34:0] GAIN_S    = 35'sd652032874;

  localparam logic [15:0] ONE_VAL = 16'(1 << OUT_FRAC);
  localparam logic [15:0] SAT_POS = 16'h7fff;
  localparam logic [15:0] SAT_NEG = 16'h8000;

  localparam logic [Q_BITS-1:0] Q_MAX   = 17'd65536;
  localparam logic [Q_BITS-1:0] POS_LIM = 17'd32767;
  localparam logic [Q_BITS-1:0] NEG_LIM = 17'd32768;

  localparam logic        REG_ZERO_THR = 1'b0;
  localparam logic [15:0] THR_RESET    = 16'd1;

  function automatic logic signed [34:0] atan_q(input logic [4:0] idx);
    logic signed [34:0] r;
    case (idx)
      5'd0:  r = 35'sd843314856;
      5'd1:  r = 35'sd497837829;
      5'd2:  r = 35'sd263043836;
      5'd3:  r = 35'sd133525158;
      5'd4:  r = 35'sd67021686;
      5'd5:  r = 35'sd33543515;
      5'd6:  r = 35'sd16775850;
      5'd7:  r = 35'sd8388437;
      5'd8:  r = 35'sd4194282;
      5'd9:  r = 35'sd2097149;
      5'd10: r = 35'sd1048575;
      5'd11: r = 35'sd524287;
      5'd12: r = 35'sd262143;
      5'd13: r = 35'sd131071;
      5'd14: r = 35'sd65535;
      5'd15: r = 35'sd32767;
      5'd16: r = 35'sd16383;
      5'd17: r = 35'sd8191;
      5'd18: r = 35'sd4095;
      5'd19: r = 35'sd2047;
      5'd20: r = 35'sd1023;
      5'd21: r = 35'sd511;
      5'd22: r = 35'sd255;
      5'd23: r = 35'sd127;
      5'd24: r = 35'sd63;
      5'd25: r = 35'sd31;
      5'd26: r = 35'sd15;
      5'd27: r = 35'sd7;
      5'd28: r = 35'sd3;
      5'd29: r = 35'sd1;
      default: r = 35'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/sf_in_if.sv
`timescale 1ns / 1ps
interface sf_in_if #(
  parameter int INPUT_WIDTH = 24
);
  logic                   valid;
  logic                   ready;
  logic [INPUT_WIDTH-1:0] sample_x;
  logic                   last_in;

  modport source (output valid, output sample_x, output last_in, input ready);
  modport sink   (input valid, input sample_x, input last_in, output ready);
endinterface

FILE: sv/sf_out_if.sv
`timescale 1ns / 1ps
interface sf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sinc_value;
  logic        last_out;

  modport source (output valid, output sinc_value, output last_out, input ready);
  modport sink   (input valid, input sinc_value, input last_out, output ready);
endinterface

FILE: sv/sinc_function_unit.sv
`timescale 1ns / 1ps
// channel   direction  handshake    payload
// in_i      sink       valid/ready  sample_x, last_in
// out_o     source     valid/ready  sinc_value, last_out
// apb       slave      psel/penable zero_threshold at byte address 0
//
// One request enters per cycle while out_o is not stalled. The pipeline has
// one register stage per modulo bit (INPUT_WIDTH - 18, at least 1), per
// CORDIC iteration and per quotient bit.
// Reset clears all valid bits and loads zero_threshold with 1.
// A result held at out_o stalls the whole pipeline; nothing is dropped.
module sinc_function_unit #(
  parameter int INPUT_WIDTH   = 24,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sf_in_if.sink       in_i,
  sf_out_if.source    out_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import sf_pkg::*;

  localparam int W      = INPUT_WIDTH;
  localparam int AW     = (W + ANG_SHIFT > 34) ? W + ANG_SHIFT : 34;
  localparam int QB     = (W > 19) ? W - 18 : 1;
  localparam int DW     = W + Q_BITS + 1;
  localparam int P_RED  = 1;
  localparam int P_F1   = P_RED + QB;
  localparam int P_F2   = P_F1 + 1;
  localparam int P_COR  = P_F2 + 1;
  localparam int P_ABS  = P_COR + CORDIC_STAGES;
  localparam int P_DIV0 = P_ABS + 1;
  localparam int P_OUT  = P_DIV0 + Q_BITS + 1;
  localparam int NS     = P_OUT + 1;

  typedef struct packed {
    logic                   last;
    logic                   one_sel;
    logic [W-1:0]           mag;
    logic [AW-1:0]          ang;
    logic signed [34:0]     cx;
    logic signed [34:0]     cy;
    logic signed [34:0]     cz;
    logic                   neg;
    logic [DW-1:0]          rem;
    logic [Q_BITS-1:0]      quo;
    logic                   sat;
    logic [15:0]            value;
  } stage_t;

  logic [15:0] thr_q, thr_d;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_ZERO_THR);
  assign thr_d    = cfg_wr ? pwdata_i[15:0] : thr_q;
  assign prdata_o = (paddr_i[2] == REG_ZERO_THR) ? {16'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else begin
      thr_q <= thr_d;
    end
  end

  logic [NS-1:0] valid_q;
  stage_t        st_q [NS];
  stage_t        st_d [NS];
  logic          adv;

  assign adv        = !valid_q[NS-1] || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    logic [W-1:0] m;
    m = in_i.sample_x[W-1] ? W'(~in_i.sample_x + 1'b1) : in_i.sample_x;
    st_d[0]         = '0;
    st_d[0].last    = in_i.last_in;
    st_d[0].mag     = m;
    st_d[0].one_sel = (m < W'(thr_q)) || (m == '0);
    st_d[0].ang     = AW'(m) << ANG_SHIFT;
  end

  for (genvar i = 1; i < NS; i++) begin : g_stage
    if (i < P_F1) begin : g_red
      localparam int K = QB - 1 - (i - P_RED);
      localparam logic [AW-1:0] SUB = AW'(TWO_PI_Q) << K;
      always_comb begin
        st_d[i] = st_q[i-1];
        if (st_q[i-1].ang >= SUB) begin
          st_d[i].ang = st_q[i-1].ang - SUB;
        end
      end
    end else if (i == P_F1) begin : g_f1
      always_comb begin
        logic signed [34:0] z;
        z = $signed({1'b0, st_q[i-1].ang[33:0]});
        st_d[i] = st_q[i-1];
        if (z > PI_S) begin
          z = z - TWO_PI_S;
        end
        st_d[i].cz = z;
      end
    end else if (i == P_F2) begin : g_f2
      always_comb begin
        logic signed [34:0] z;
        z = st_q[i-1].cz;
        st_d[i] = st_q[i-1];
        if (z > HALF_PI_S) begin
          z = PI_S - z;
        end else if (z < -HALF_PI_S) begin
          z = -PI_S - z;
        end
        st_d[i].cz = z;
        st_d[i].cx = GAIN_S;
        st_d[i].cy = '0;
      end
    end else if (i < P_ABS) begin : g_cor
      localparam int J = i - P_COR;
      always_comb begin
        logic signed [34:0] px, py, pz, dx, dy, at;
        px = st_q[i-1].cx;
        py = st_q[i-1].cy;
        pz = st_q[i-1].cz;
        dx = py >>> J;
        dy = px >>> J;
        at = atan_q(5'(J));
        st_d[i] = st_q[i-1];
        if (pz >= 0) begin
          st_d[i].cx = px - dx;
          st_d[i].cy = py + dy;
          st_d[i].cz = pz - at;
        end else begin
          st_d[i].cx = px + dx;
          st_d[i].cy = py - dy;
          st_d[i].cz = pz + at;
        end
      end
    end else if (i == P_ABS) begin : g_abs
      always_comb begin
        logic signed [34:0] s, a;
        s = st_q[i-1].cy;
        a = (s < 0) ? -s : s;
        st_d[i]     = st_q[i-1];
        st_d[i].neg = s < 0;
        st_d[i].rem = DW'(a[33:0]);
      end
    end else if (i == P_DIV0) begin : g_div0
      always_comb begin
        logic [DW-1:0] n;
        n = st_q[i-1].rem + DW'(st_q[i-1].mag >> 1);
        st_d[i]     = st_q[i-1];
        st_d[i].rem = n;
        st_d[i].quo = '0;
        st_d[i].sat = n >= (DW'(st_q[i-1].mag) << Q_BITS);
      end
    end else if (i < P_OUT) begin : g_div
      localparam int K = Q_BITS - 1 - (i - P_DIV0 - 1);
      always_comb begin
        logic [DW-1:0] sh;
        sh = DW'(st_q[i-1].mag) << K;
        st_d[i] = st_q[i-1];
        if (st_q[i-1].rem >= sh) begin
          st_d[i].rem    = st_q[i-1].rem - sh;
          st_d[i].quo[K] = 1'b1;
        end
      end
    end else begin : g_out
      always_comb begin
        logic [Q_BITS-1:0] qc, nq;
        qc = (st_q[i-1].sat || st_q[i-1].quo > Q_MAX) ? Q_MAX : st_q[i-1].quo;
        nq = ~qc + 1'b1;
        st_d[i] = st_q[i-1];
        if (st_q[i-1].one_sel) begin
          st_d[i].value = ONE_VAL;
        end else if (!st_q[i-1].neg) begin
          st_d[i].value = (qc > POS_LIM) ? SAT_POS : qc[15:0];
        end else begin
          st_d[i].value = (qc > NEG_LIM) ? SAT_NEG : nq[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NS-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_o.valid      = valid_q[NS-1];
  assign out_o.sinc_value = st_q[NS-1].value;
  assign out_o.last_out   = st_q[NS-1].last;

`ifndef SYNTHESIS
  a_one_forced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NS-1] && st_q[NS-1].one_sel |-> st_q[NS-1].value == ONE_VAL)
    else $error("forced result is not one");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("pipeline moved while stalled");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> valid_q[0])
    else $error("accepted request lost");
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[P_F1-1] |-> st_q[P_F1-1].ang < AW'(TWO_PI_Q))
    else $error("angle not reduced below two pi");
`endif

endmodule
